FILE: design/lcwb_pkg.sv
// ----------------------------------------------------------------------------
// lcwb_pkg: shared constants for the load cell weight and balance block
// Fixed-point scales, divider sizes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package lcwb_pkg;

    // 17 kg in 1/256 kg
    localparam int unsigned KG17_LSB        = 4352;
    // 0.01 kg threshold on the total, in LSB
    localparam int signed   TOTAL_THRESHOLD = 3;
    localparam int unsigned Q14_SHIFT       = 14;

    localparam int unsigned RAW_W  = 16;
    localparam int unsigned CAL_W  = 48;
    localparam int unsigned W_W    = 24;
    localparam int unsigned B_W    = 16;

    // corner divider: |4352 * diff| < 2^29, denominator 16 bits
    localparam int unsigned CORNER_NW = 29;
    localparam int unsigned CORNER_DW = 16;
    localparam int unsigned CORNER_QW = 29;

    // balance divider: |16384 * diff| < 2^40, total below 2^23
    localparam int unsigned COG_NW = 40;
    localparam int unsigned COG_DW = 23;
    localparam int unsigned COG_QW = 15;

    // register indexes
    localparam logic [2:0] REG_CAL_TR    = 3'd0;
    localparam logic [2:0] REG_CAL_BR    = 3'd1;
    localparam logic [2:0] REG_CAL_TL    = 3'd2;
    localparam logic [2:0] REG_CAL_BL    = 3'd3;
    localparam logic [2:0] REG_CAL_VALID = 3'd4;

endpackage
`default_nettype wire

FILE: design/lcwb_div.sv
// ----------------------------------------------------------------------------
// lcwb_div: pipelined unsigned restoring divider
// One quotient bit per stage; a sideband word travels alongside.
// Requires num < den << QW.
// ----------------------------------------------------------------------------
`default_nettype none
module lcwb_div #(
    parameter int unsigned NW = lcwb_pkg::CORNER_NW,
    parameter int unsigned DW = lcwb_pkg::CORNER_DW,
    parameter int unsigned QW = lcwb_pkg::CORNER_QW,
    parameter int unsigned SW = 3
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      out_side
);

    localparam int unsigned TW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [QW];
    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic          vld_in;
            logic [NW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] quo_in;
            logic [SW-1:0] side_in;
            logic [TW-1:0] trial;
            logic [TW-1:0] rem_ext;
            logic [NW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            if (k == 0) begin : g_first
                assign vld_in  = in_valid;
                assign rem_in  = num;
                assign den_in  = den;
                assign quo_in  = '0;
                assign side_in = side;
            end else begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign quo_in  = quo_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // trial subtract of den shifted to this bit position
            always_comb begin
                trial    = TW'(den_in) << (QW - 1 - k);
                rem_ext  = TW'(rem_in);
                rem_next = rem_in;
                quo_next = quo_in;
                if (rem_ext >= trial) begin
                    rem_next           = NW'(rem_ext - trial);
                    quo_next[QW-1-k]   = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    vld_reg[k]  <= vld_in;
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_in;
                    quo_reg[k]  <= quo_next;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

FILE: design/lcwb_lane.sv
// ----------------------------------------------------------------------------
// lcwb_lane: one corner of the weight conversion
// Picks the calibration segment, divides, then offsets and saturates.
// ----------------------------------------------------------------------------
`default_nettype none
module lcwb_lane (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              in_valid,
    input  wire logic [lcwb_pkg::RAW_W-1:0]        reading,
    input  wire logic [lcwb_pkg::CAL_W-1:0]        cal,
    output logic                                   out_valid,
    output logic signed [lcwb_pkg::W_W-1:0]        weight
);

    localparam int unsigned QW = lcwb_pkg::CORNER_QW;

    logic signed [16:0] r, c0, c17, c34, a, b;
    logic               upper, flat, neg;
    logic [15:0]        amag, bmag;
    logic [lcwb_pkg::CORNER_NW-1:0] num;
    logic [2:0]         side, side_o;
    logic [QW-1:0]      q;
    logic signed [QW+1:0] sq, wv;

    // segment selection and magnitudes
    always_comb begin
        r     = signed'({1'b0, reading});
        c0    = signed'({1'b0, cal[15:0]});
        c17   = signed'({1'b0, cal[31:16]});
        c34   = signed'({1'b0, cal[47:32]});
        upper = r > c17;
        a     = upper ? r - c17 : r - c0;
        b     = upper ? c34 - c17 : c17 - c0;
        flat  = (b == 17'sd0);
        neg   = a[16] ^ b[16];
        amag  = a[16] ? 16'(-a) : a[15:0];
        bmag  = b[16] ? 16'(-b) : b[15:0];
        num   = lcwb_pkg::CORNER_NW'(amag) * lcwb_pkg::CORNER_NW'(lcwb_pkg::KG17_LSB);
        side  = {upper, flat, neg};
    end

    lcwb_div #(
        .NW(lcwb_pkg::CORNER_NW), .DW(lcwb_pkg::CORNER_DW), .QW(QW), .SW(3)
    ) u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(in_valid),
        .num(num), .den(bmag), .side(side),
        .out_valid(out_valid), .quo(q), .out_side(side_o)
    );

    // sign, segment offset, flat cases and saturation
    always_comb begin
        sq = side_o[0] ? -signed'((QW+2)'(q)) : signed'((QW+2)'(q));
        if (side_o[1])
            wv = side_o[2] ? (QW+2)'(lcwb_pkg::KG17_LSB) : '0;
        else
            wv = side_o[2] ? sq + (QW+2)'(lcwb_pkg::KG17_LSB) : sq;
        if (wv > (QW+2)'(24'sh7FFFFF))
            weight = 24'sh7FFFFF;
        else if (wv < -(QW+2)'(25'sh0800000))
            weight = -24'sh800000;
        else
            weight = wv[23:0];
    end

endmodule
`default_nettype wire

FILE: design/load_cell_weight_and_balance.sv
// ----------------------------------------------------------------------------
// load_cell_weight_and_balance: four-corner weight and centre of gravity
// Pipeline: 29 corner divider stages, 2 merge stages, 15 balance divider
// stages and the output register. Throughput one beat per cycle when not stalled.
// Any output stall freezes the whole pipeline (s_tready follows it).
// Synchronous active-low reset clears valid bits and calibration registers.
// ----------------------------------------------------------------------------
`default_nettype none
module load_cell_weight_and_balance (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // tr[15:0] br[31:16] tl[47:32] bl[63:48] temperature[71:64] battery[79:72]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [79:0]  s_tdata,
    // w_tr[23:0] w_br[47:24] w_tl[71:48] w_bl[95:72] total[119:96]
    // balance_x[135:120] balance_y[151:136] temperature[159:152] battery[167:160]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,
    // weights_valid[0]
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data
);

    localparam int unsigned CQ = lcwb_pkg::CORNER_QW;
    localparam int unsigned BQ = lcwb_pkg::COG_QW;

    typedef struct packed {
        logic              negx;
        logic              ovfx;
        logic              zero;
        logic [3:0][23:0]  w;
        logic [23:0]       total;
        logic              calv;
        logic [7:0]        temp;
        logic [7:0]        batt;
    } cog_side_t;

    logic        adv;
    logic [47:0] cal_reg [4];
    logic        calv_reg;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) cal_reg[i] <= '0;
            calv_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lcwb_pkg::REG_CAL_TR:    cal_reg[0] <= cfg_data;
                lcwb_pkg::REG_CAL_BR:    cal_reg[1] <= cfg_data;
                lcwb_pkg::REG_CAL_TL:    cal_reg[2] <= cfg_data;
                lcwb_pkg::REG_CAL_BL:    cal_reg[3] <= cfg_data;
                lcwb_pkg::REG_CAL_VALID: calv_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register can take a beat
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    logic        in_fire;
    logic        lane_vld;
    logic signed [23:0] lane_w [4];
    assign in_fire = s_tvalid && adv;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            if (g == 0) begin : g_v
                lcwb_lane u_lane (
                    .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(in_fire),
                    .reading(s_tdata[16*g +: 16]), .cal(cal_reg[g]),
                    .out_valid(lane_vld), .weight(lane_w[g])
                );
            end else begin : g_nv
                lcwb_lane u_lane (
                    .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(in_fire),
                    .reading(s_tdata[16*g +: 16]), .cal(cal_reg[g]),
                    .out_valid(), .weight(lane_w[g])
                );
            end
        end
    endgenerate

    // pass-through bytes and calibration flag, matched to the lanes
    logic [16:0] pt_reg [CQ];
    always_ff @(posedge aclk) begin
        if (adv) begin
            pt_reg[0] <= {calv_reg, s_tdata[79:72], s_tdata[71:64]};
            for (int i = 1; i < CQ; i++) pt_reg[i] <= pt_reg[i-1];
        end
    end

    // merge stage 1: corner weights, zeroed when calibration is invalid
    logic              m1_vld_reg;
    logic signed [23:0] m1_w_reg [4];
    logic [16:0]       m1_pt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (adv) begin
            m1_vld_reg <= lane_vld;
            for (int i = 0; i < 4; i++)
                m1_w_reg[i] <= pt_reg[CQ-1][16] ? lane_w[i] : '0;
            m1_pt_reg <= pt_reg[CQ-1];
        end
    end

    // merge stage 2: total and the two differences
    logic signed [25:0] sum_next;
    logic signed [23:0] total_next;
    logic              m2_vld_reg;
    logic signed [23:0] m2_w_reg [4];
    logic signed [23:0] m2_total_reg;
    logic signed [25:0] m2_dx_reg, m2_dy_reg;
    logic [16:0]       m2_pt_reg;
    always_comb begin
        sum_next = 26'(m1_w_reg[0]) + 26'(m1_w_reg[1]) + 26'(m1_w_reg[2])
                 + 26'(m1_w_reg[3]);
        if (sum_next > 26'sh07FFFFF)       total_next = 24'sh7FFFFF;
        else if (sum_next < -26'sh0800000) total_next = -24'sh800000;
        else                               total_next = sum_next[23:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (adv) begin
            m2_vld_reg   <= m1_vld_reg;
            m2_w_reg     <= m1_w_reg;
            m2_total_reg <= total_next;
            m2_dx_reg    <= (26'(m1_w_reg[0]) + 26'(m1_w_reg[1]))
                          - (26'(m1_w_reg[2]) + 26'(m1_w_reg[3]));
            m2_dy_reg    <= (26'(m1_w_reg[0]) + 26'(m1_w_reg[2]))
                          - (26'(m1_w_reg[1]) + 26'(m1_w_reg[3]));
            m2_pt_reg    <= m1_pt_reg;
        end
    end

    // balance operands and saturation check
    logic [24:0]  dxm, dym;
    logic [39:0]  nx, ny, lim;
    logic         ovfx, ovfy, zero;
    cog_side_t    sx, sx_o;
    logic [1:0]   sy, sy_o;
    logic         bx_vld;
    logic [BQ-1:0] qx, qy;
    always_comb begin
        dxm  = m2_dx_reg[25] ? 25'(-m2_dx_reg) : m2_dx_reg[24:0];
        dym  = m2_dy_reg[25] ? 25'(-m2_dy_reg) : m2_dy_reg[24:0];
        nx   = 40'(dxm) << lcwb_pkg::Q14_SHIFT;
        ny   = 40'(dym) << lcwb_pkg::Q14_SHIFT;
        lim  = 40'(m2_total_reg[22:0]) << BQ;
        ovfx = nx >= lim;
        ovfy = ny >= lim;
        zero = m2_total_reg <= 24'(lcwb_pkg::TOTAL_THRESHOLD);
        sx.negx  = m2_dx_reg[25];
        sx.ovfx  = ovfx;
        sx.zero  = zero;
        for (int i = 0; i < 4; i++) sx.w[i] = m2_w_reg[i];
        sx.total = m2_total_reg;
        sx.calv  = m2_pt_reg[16];
        sx.batt  = m2_pt_reg[15:8];
        sx.temp  = m2_pt_reg[7:0];
        sy       = {m2_dy_reg[25], ovfy};
    end

    lcwb_div #(
        .NW(lcwb_pkg::COG_NW), .DW(lcwb_pkg::COG_DW), .QW(BQ), .SW($bits(cog_side_t))
    ) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(m2_vld_reg),
        .num(nx), .den(m2_total_reg[22:0]), .side(sx),
        .out_valid(bx_vld), .quo(qx), .out_side(sx_o)
    );

    lcwb_div #(
        .NW(lcwb_pkg::COG_NW), .DW(lcwb_pkg::COG_DW), .QW(BQ), .SW(2)
    ) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(m2_vld_reg),
        .num(ny), .den(m2_total_reg[22:0]), .side(sy),
        .out_valid(), .quo(qy), .out_side(sy_o)
    );

    // final balance values
    logic [15:0] bx_next, by_next;
    always_comb begin
        if (sx_o.zero)       bx_next = '0;
        else if (sx_o.ovfx)  bx_next = sx_o.negx ? 16'h8000 : 16'h7FFF;
        else                 bx_next = sx_o.negx ? 16'(-{1'b0, qx}) : {1'b0, qx};
        if (sx_o.zero)       by_next = '0;
        else if (sy_o[0])    by_next = sy_o[1] ? 16'h8000 : 16'h7FFF;
        else                 by_next = sy_o[1] ? 16'(-{1'b0, qy}) : {1'b0, qy};
    end

    // output register
    logic          out_vld_reg;
    logic [167:0]  out_data_reg;
    logic          out_user_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg  <= bx_vld;
            out_data_reg <= {sx_o.batt, sx_o.temp, by_next, bx_next, sx_o.total,
                             sx_o.w[3], sx_o.w[2], sx_o.w[1], sx_o.w[0]};
            out_user_reg <= sx_o.calv;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    // invalid calibration gives zero weights and balance
    a_zero_when_uncal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[151:0] == '0)
        else $error("weights not zero with calibration invalid");

    // small total gives zero balance
    a_small_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ($signed(m_tdata[119:96]) <= 24'sd3)
        |-> m_tdata[151:120] == '0)
        else $error("balance not zero for small total");

    // a stalled output holds the input side too
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

endmodule
`default_nettype wire

FILE: sim/load_cell_weight_and_balance_checker.sv
// ----------------------------------------------------------------------------
// load_cell_weight_and_balance_checker: result scoreboard
// Watches the config, input and result channels, predicts each result from a
// shadow copy of the calibration registers and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module load_cell_weight_and_balance_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [79:0]  s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [167:0] m_tdata,
    input  wire logic [0:0]   m_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    // signed copies so the arithmetic below stays signed
    localparam longint KG17 = lcwb_pkg::KG17_LSB;
    localparam longint THRESH = lcwb_pkg::TOTAL_THRESHOLD;

    typedef struct packed {
        logic [7:0]  battery;
        logic [7:0]  temperature;
        logic [15:0] bal_y;
        logic [15:0] bal_x;
        logic [23:0] total;
        logic [23:0] w_bl;
        logic [23:0] w_tl;
        logic [23:0] w_br;
        logic [23:0] w_tr;
    } weigh_beat_t;

    typedef struct {
        weigh_beat_t data;
        logic        wvalid;
    } weigh_result_t;

    logic [47:0]   cal_shadow [4];
    logic          cal_ok;
    weigh_result_t weigh_queue [$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // piecewise-linear corner weight, 1/256 kg
    function automatic longint corner_kg(logic [15:0] raw, logic [47:0] cal);
        longint r, c0, c17, c34;
        r   = raw;
        c0  = cal[15:0];
        c17 = cal[31:16];
        c34 = cal[47:32];
        if (r <= c17) begin
            if (c17 == c0) return 0;
            return clamp(KG17 * (r - c0) / (c17 - c0), -8388608, 8388607);
        end
        if (c34 == c17) return KG17;
        return clamp(KG17 + KG17 * (r - c17) / (c34 - c17), -8388608, 8388607);
    endfunction

    function automatic weigh_result_t predict_weigh(logic [79:0] d);
        weigh_result_t res;
        longint w [4];
        longint tot, bx, by;
        tot = 0; bx = 0; by = 0;
        for (int i = 0; i < 4; i++) w[i] = 0;
        if (cal_ok) begin
            for (int i = 0; i < 4; i++) w[i] = corner_kg(d[16*i +: 16], cal_shadow[i]);
            tot = clamp(w[0] + w[1] + w[2] + w[3], -8388608, 8388607);
            if (tot > THRESH) begin
                bx = clamp(16384 * ((w[0] + w[1]) - (w[2] + w[3])) / tot, -32768, 32767);
                by = clamp(16384 * ((w[0] + w[2]) - (w[1] + w[3])) / tot, -32768, 32767);
            end
        end
        res.data.w_tr        = w[0][23:0];
        res.data.w_br        = w[1][23:0];
        res.data.w_tl        = w[2][23:0];
        res.data.w_bl        = w[3][23:0];
        res.data.total       = tot[23:0];
        res.data.bal_x       = bx[15:0];
        res.data.bal_y       = by[15:0];
        res.data.temperature = d[71:64];
        res.data.battery     = d[79:72];
        res.wvalid           = cal_ok;
        return res;
    endfunction

    assign pending = weigh_queue.size();

    always @(posedge aclk) begin
        weigh_result_t exp_r;
        weigh_beat_t   got;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) cal_shadow[i] <= '0;
            cal_ok     <= 1'b0;
            fail_count <= 0;
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < lcwb_pkg::REG_CAL_VALID)
                    cal_shadow[cfg_index[1:0]] <= cfg_data;
                else if (cfg_index == lcwb_pkg::REG_CAL_VALID)
                    cal_ok <= cfg_data[0];
            end
            // input beat
            if (s_tvalid && s_tready) weigh_queue.push_back(predict_weigh(s_tdata));
            // result beat
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (weigh_queue.size() == 0) begin
                    $error("unexpected result beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = weigh_queue.pop_front();
                    if (exp_r.data.w_tr !== got.w_tr)
                        $error("weight_top_right exp %h got %h", exp_r.data.w_tr, got.w_tr);
                    if (exp_r.data.w_br !== got.w_br)
                        $error("weight_bottom_right exp %h got %h", exp_r.data.w_br, got.w_br);
                    if (exp_r.data.w_tl !== got.w_tl)
                        $error("weight_top_left exp %h got %h", exp_r.data.w_tl, got.w_tl);
                    if (exp_r.data.w_bl !== got.w_bl)
                        $error("weight_bottom_left exp %h got %h", exp_r.data.w_bl, got.w_bl);
                    if (exp_r.data.total !== got.total)
                        $error("weight_total exp %h got %h", exp_r.data.total, got.total);
                    if (exp_r.data.bal_x !== got.bal_x)
                        $error("balance_x exp %h got %h", exp_r.data.bal_x, got.bal_x);
                    if (exp_r.data.bal_y !== got.bal_y)
                        $error("balance_y exp %h got %h", exp_r.data.bal_y, got.bal_y);
                    if (exp_r.data.temperature !== got.temperature)
                        $error("temperature_out exp %h got %h",
                               exp_r.data.temperature, got.temperature);
                    if (exp_r.data.battery !== got.battery)
                        $error("battery_out exp %h got %h", exp_r.data.battery, got.battery);
                    if (exp_r.wvalid !== m_tuser[0])
                        $error("weights_valid exp %b got %b", exp_r.wvalid, m_tuser[0]);
                    if (exp_r.data !== got || exp_r.wvalid !== m_tuser[0])
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sim/load_cell_weight_and_balance_test.sv
// ----------------------------------------------------------------------------
// load_cell_weight_and_balance_test: stimulus and verdict
// Runs several calibration phases (invalid, all-zero, ascending/descending/extreme,
// random) with directed and random readings, bursty input and a stalling sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module load_cell_weight_and_balance_test;

    localparam int LATENCY   = 47;
    localparam int MAX_CYCLE = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [47:0]  cfg_data = '0;
    int           fail_count;
    int           pending;
    int           cycle = 0;
    logic         sink_run = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    load_cell_weight_and_balance dut (.*);
    load_cell_weight_and_balance_checker chk (.*);

    // timeout watchdog
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("** load_cell_weight_and_balance: FAILED **");
            $finish;
        end
    end

    // sink stall pattern: long ready runs, short and long stalls
    always @(negedge aclk) begin
        if (!sink_run) m_tready <= 1'b0;
        else case (cycle[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycle[3:0] != 4'd7);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_cal(logic [47:0] tr, logic [47:0] br, logic [47:0] tl,
                           logic [47:0] bl, logic ok);
        write_reg(lcwb_pkg::REG_CAL_TR, tr);
        write_reg(lcwb_pkg::REG_CAL_BR, br);
        write_reg(lcwb_pkg::REG_CAL_TL, tl);
        write_reg(lcwb_pkg::REG_CAL_BL, bl);
        write_reg(lcwb_pkg::REG_CAL_VALID, {47'd0, ok});
    endtask

    task automatic send_reading(logic [79:0] d);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // readings near the calibration points, at the extremes, or anywhere
    function automatic logic [15:0] pick_raw(logic [47:0] cal);
        int sel;
        sel = $urandom_range(0, 5);
        case (sel)
            0, 1:    return cal[15 + 16 * $urandom_range(0, 2) -: 16]
                            + 16'($urandom_range(0, 40)) - 16'd20;
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] random_cal();
        logic [15:0] c0, c17, c34;
        c0 = 16'($urandom());
        case ($urandom_range(0, 4))
            0: begin c17 = 16'($urandom()); c34 = 16'($urandom()); end
            1: begin c17 = c0; c34 = c0 + 16'($urandom_range(0, 3000)); end
            default: begin
                c0  = 16'($urandom_range(0, 20000));
                c17 = c0 + 16'($urandom_range(1, 20000));
                c34 = ($urandom_range(0, 7) == 0) ? c17
                      : c17 + 16'($urandom_range(1, 20000));
            end
        endcase
        return {c34, c17, c0};
    endfunction

    task automatic run_random(int count, logic [47:0] cal [4]);
        logic [79:0] d;
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && count > 0; b++, count--) begin
                for (int c = 0; c < 4; c++) d[16*c +: 16] = pick_raw(cal[c]);
                d[79:64] = 16'($urandom());
                send_reading(d);
            end
            if ($urandom_range(0, 3) != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    initial begin
        logic [47:0] cal [4];
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn  <= 1'b1;
        sink_run <= 1'b1;

        // invalid calibration: weights zero, bytes pass through
        send_reading(80'hFFFF_FFFF_FFFF_FFFF_FFFF);
        send_reading(80'h0);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();

        // valid with all-zero calibration: every segment flat
        set_cal('0, '0, '0, '0, 1'b1);
        send_reading({16'hA55A, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_reading({16'h5AA5, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001});
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();

        // ascending, descending and extreme-span calibrations
        cal[0] = {16'd30000, 16'd20000, 16'd10000};
        cal[1] = {16'd1000,  16'd2000,  16'd3000};
        cal[2] = {16'hFFFF,  16'd1,     16'd0};
        cal[3] = {16'd1,     16'd0,     16'hFFFF};
        set_cal(cal[0], cal[1], cal[2], cal[3], 1'b1);
        send_reading({16'h1234, 16'd0, 16'd0, 16'd0, 16'd0});
        send_reading({16'h4321, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_reading({16'h0000, 16'd1, 16'd1, 16'd2000, 16'd20000});
        send_reading({16'h00FF, 16'd0, 16'd2, 16'd1000, 16'd30000});
        send_reading({16'hFF00, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF});
        send_reading({16'h0F0F, 16'd0, 16'hFFFF, 16'd3000, 16'd10000});
        send_reading({16'hF0F0, 16'd0, 16'd0, 16'd3000, 16'd10001});
        @(negedge aclk);
        s_tvalid <= 1'b0;
        drain();
        run_random(150, cal);
        drain();

        // random calibration phases, one with calibration turned off
        for (int p = 0; p < 5; p++) begin
            for (int c = 0; c < 4; c++) cal[c] = random_cal();
            set_cal(cal[0], cal[1], cal[2], cal[3], (p != 2));
            run_random(160, cal);
            drain();
        end

        if (fail_count == 0) $display("** load_cell_weight_and_balance: PASSED **");
        else $display("** load_cell_weight_and_balance: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
